// ===== design/atce_pkg.sv =====
// Shared types, constants and helper functions for the text console engine.
// No dependencies; imported by ansi_text_console_engine_core.
`default_nettype none

package atce_pkg;

  localparam int unsigned ColumnsDef = 80;
  localparam int unsigned RowsDef    = 25;

  localparam logic [7:0] AttrReset = 8'h0F;
  localparam logic [7:0] EscByte   = 8'h1B;
  localparam logic [7:0] BsByte    = 8'h08;
  localparam logic [7:0] NlByte    = 8'h0A;
  localparam logic [9:0] NumMax    = 10'd999;

  // input modes
  localparam logic [1:0] ModeParse = 2'd0;
  localparam logic [1:0] ModeRaw   = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_byte;
    logic [10:0] read_cell;
  } in_t;

  typedef struct packed {
    logic [10:0] cursor_cell;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [7:0]  attribute;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } out_t;

  // ANSI color index to attribute color
  function automatic logic [3:0] sgr_map(logic [2:0] idx);
    logic [3:0] r;
    case (idx)
      3'd0: r = 4'h0;
      3'd1: r = 4'h4;
      3'd2: r = 4'h2;
      3'd3: r = 4'h6;
      3'd4: r = 4'h1;
      3'd5: r = 4'h5;
      3'd6: r = 4'h3;
      default: r = 4'h7;
    endcase
    return r;
  endfunction

  // Append one decimal digit, saturating
  function automatic logic [9:0] add_digit(logic [9:0] v, logic [7:0] b);
    logic [13:0] s;
    s = 14'(v) * 14'd10 + {10'd0, b[3:0]};
    return (s > 14'(NumMax)) ? NumMax : s[9:0];
  endfunction

  // Apply one SGR code to an attribute
  function automatic logic [7:0] set_colour(logic [9:0] n, logic [7:0] a);
    logic [7:0] r;
    logic [9:0] k;
    r = a;
    k = 10'd0;
    if (n == 10'd0) begin
      r = AttrReset;
    end else if (n >= 10'd30 && n <= 10'd37) begin
      k = n - 10'd30;
      r = {a[7:4], sgr_map(k[2:0])};
    end else if (n >= 10'd40 && n <= 10'd47) begin
      k = n - 10'd40;
      r = {sgr_map(k[2:0]), a[3:0]};
    end else if (n >= 10'd90 && n <= 10'd97) begin
      k = n - 10'd90;
      r = {a[7:4], sgr_map(k[2:0]) + 4'd8};
    end else if (n >= 10'd100 && n <= 10'd107) begin
      k = n - 10'd100;
      r = {sgr_map(k[2:0]) + 4'd8, a[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/ansi_text_console_engine_core.sv =====
// Text console engine: escape parser, cursor control and screen cell store.
// Depends on atce_pkg for payload types, byte codes and SGR/digit helpers.
//
// Usage: one input beat gives one result beat. After reset the block clears
// the screen store and stalls its input meanwhile. A plain byte, backspace
// or cell read goes through accept, decode, one store access (cell write or
// registered read) and result load; escape bytes and cursor moves skip the
// store access. The cell memory has one write and one read port; a clear
// (J, K) writes the cleared cells one at a time, and a line break on the last
// row scrolls by reading and then writing each copied cell, then blanks the
// last row. Items are handled one at a time.
`default_nettype none

module ansi_text_console_engine_core
  import atce_pkg::*;
#(
  parameter int unsigned COLUMNS = ColumnsDef,
  parameter int unsigned ROWS    = RowsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned AW    = $clog2(CELLS + 1);
  localparam int unsigned IW    = $clog2(CELLS);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RDWAIT, S_SCR_RD, S_SCR_WR, S_FILL, S_WCELL, S_DONE
  } state_e;

  typedef enum logic [1:0] { P_IDLE, P_DONE, P_PUT, P_HOME } post_e;

  typedef enum logic [1:0] { PS_NORMAL, PS_START, PS_FIRST, PS_SECOND } pstate_e;

  state_e        state_q;
  post_e         post_q;
  pstate_e       ps_q;
  in_t           in_q;
  out_t          out_q;
  logic          out_valid_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [7:0]    attr_q;
  logic [9:0]    n1_q, n2_q;
  logic [AW-1:0] ptr_q, fend_q;
  logic [15:0]   fval_q;
  logic [7:0]    wchar_q;
  logic          inc_q;
  logic [15:0]   cell_q;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_q;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [15:0]   wdata;

  logic [AW-1:0] base, cur;
  logic [7:0]    b;
  logic          digit, parse_put, do_put, put_brk, put_scroll, put_write;
  logic [AW-1:0] j_start, j_end, k_start, k_end;

  // cursor cell and byte classification
  assign base      = AW'(row_q) * AW'(COLUMNS);
  assign cur       = base + AW'(col_q);
  assign b         = in_q.char_byte;
  assign digit     = (b >= 8'h30) && (b <= 8'h39);
  assign parse_put = (ps_q == PS_NORMAL) && (b != EscByte) && (b != BsByte);
  assign do_put    = (in_q.mode == ModeRaw) || ((in_q.mode == ModeParse) && parse_put);
  assign put_brk   = (col_q == CW'(COLUMNS)) || (b == NlByte);
  assign put_scroll = put_brk && (row_q == RW'(ROWS - 1));
  assign put_write = (b != NlByte) && (b != 8'h00);

  // clear ranges for J and K
  always_comb begin
    if (n1_q == 10'd0) begin
      j_start = cur;
      j_end   = AW'(CELLS);
      k_start = cur;
      k_end   = base + AW'(COLUMNS);
    end else if (n1_q == 10'd1) begin
      j_start = '0;
      j_end   = cur;
      k_start = base;
      k_end   = cur;
    end else begin
      j_start = '0;
      j_end   = AW'(CELLS);
      k_start = base;
      k_end   = base + AW'(COLUMNS);
    end
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q[IW-1:0];
    wdata = fval_q;
    raddr = IW'(in_q.read_cell);
    case (state_q)
      S_SCR_RD: raddr = IW'(ptr_q + AW'(COLUMNS));
      S_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      S_FILL: we = 1'b1;
      S_WCELL: begin
        we    = 1'b1;
        waddr = IW'(cur);
        wdata = {attr_q, wchar_q};
      end
      default: we = 1'b0;
    endcase
  end

  // cell store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      post_q      <= P_IDLE;
      ps_q        <= PS_NORMAL;
      row_q       <= '0;
      col_q       <= '0;
      attr_q      <= AttrReset;
      n1_q        <= '0;
      n2_q        <= '0;
      ptr_q       <= '0;
      fend_q      <= AW'(CELLS);
      fval_q      <= {AttrReset, 8'h00};
      out_valid_q <= 1'b0;
      inc_q       <= 1'b0;
      wchar_q     <= '0;
      cell_q      <= '0;
      in_q        <= '0;
      out_q       <= '0;
    end else begin
      // drop the result beat once taken, unless a new one loads now
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            cell_q  <= '0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_DONE;
          if (do_put) begin
            if (put_brk) begin
              col_q <= '0;
              if (!put_scroll) begin
                row_q <= row_q + RW'(1);
              end
            end
            wchar_q <= b;
            inc_q   <= 1'b1;
            if (put_scroll) begin
              ptr_q   <= '0;
              post_q  <= put_write ? P_PUT : P_DONE;
              state_q <= S_SCR_RD;
            end else if (put_write) begin
              state_q <= S_WCELL;
            end
          end else if (in_q.mode == ModeParse) begin
            if (ps_q == PS_NORMAL && b == EscByte) begin
              ps_q <= PS_START;
              n1_q <= '0;
              n2_q <= '0;
            end else if (ps_q == PS_START && b == 8'h5B) begin
              ps_q <= PS_FIRST;
            end else if (ps_q == PS_FIRST && digit) begin
              n1_q <= add_digit(n1_q, b);
            end else if (ps_q == PS_SECOND && digit) begin
              n2_q <= add_digit(n2_q, b);
            end else if (ps_q == PS_FIRST && b == 8'h3B) begin
              ps_q <= PS_SECOND;
            end else if (ps_q == PS_FIRST && b == 8'h47) begin
              col_q <= (n1_q > 10'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(n1_q);
              ps_q  <= PS_NORMAL;
            end else if (ps_q == PS_SECOND && b == 8'h48) begin
              row_q <= (n1_q > 10'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(n1_q);
              col_q <= (n2_q > 10'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(n2_q);
              ps_q  <= PS_NORMAL;
            end else if (ps_q == PS_FIRST && b == 8'h4A) begin
              ps_q   <= PS_NORMAL;
              fval_q <= {attr_q, 8'h00};
              ptr_q  <= j_start;
              fend_q <= j_end;
              if (j_start < j_end) begin
                post_q  <= P_HOME;
                state_q <= S_FILL;
              end else begin
                row_q <= '0;
                col_q <= '0;
              end
            end else if (ps_q == PS_FIRST && b == 8'h4B) begin
              ps_q   <= PS_NORMAL;
              fval_q <= {attr_q, 8'h00};
              ptr_q  <= k_start;
              fend_q <= k_end;
              if (k_start < k_end) begin
                post_q  <= P_DONE;
                state_q <= S_FILL;
              end
            end else if (ps_q == PS_FIRST && b == 8'h6D) begin
              attr_q <= set_colour(n1_q, attr_q);
              ps_q   <= PS_NORMAL;
            end else if (ps_q != PS_NORMAL) begin
              ps_q <= PS_NORMAL;
            end else begin
              // backspace: step back, then blank the cell
              if (col_q == '0 && row_q != '0) begin
                row_q <= row_q - RW'(1);
                col_q <= CW'(COLUMNS - 1);
              end else if (col_q != '0) begin
                col_q <= col_q - CW'(1);
              end
              wchar_q <= 8'h00;
              inc_q   <= 1'b0;
              state_q <= S_WCELL;
            end
          end else if (in_q.mode == ModeRead) begin
            if (32'(in_q.read_cell) < CELLS) begin
              state_q <= S_RDWAIT;
            end
          end
        end
        S_RDWAIT: begin
          cell_q  <= rdata_q;
          state_q <= S_DONE;
        end
        S_SCR_RD: state_q <= S_SCR_WR;
        S_SCR_WR: begin
          if (ptr_q == AW'(CELLS - COLUMNS - 1)) begin
            ptr_q   <= AW'(CELLS - COLUMNS);
            fend_q  <= AW'(CELLS);
            fval_q  <= 16'h0000;
            state_q <= S_FILL;
          end else begin
            ptr_q   <= ptr_q + AW'(1);
            state_q <= S_SCR_RD;
          end
        end
        S_FILL: begin
          if (ptr_q + AW'(1) >= fend_q) begin
            case (post_q)
              P_IDLE: state_q <= S_IDLE;
              P_PUT:  state_q <= S_WCELL;
              P_HOME: begin
                row_q   <= '0;
                col_q   <= '0;
                state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end else begin
            ptr_q <= ptr_q + AW'(1);
          end
        end
        S_WCELL: begin
          if (inc_q) begin
            col_q <= col_q + CW'(1);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          // load the result beat when the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_q.cursor_cell <= 11'(cur);
            out_q.cursor_row  <= 5'(row_q);
            out_q.cursor_col  <= 7'(col_q);
            out_q.attribute   <= attr_q;
            out_q.cell_char   <= cell_q[7:0];
            out_q.cell_attr   <= cell_q[15:8];
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // cursor row stays inside the screen, column at most COLUMNS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) <= COLUMNS))
    else $error("cursor out of range");

  // store writes never leave the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (32'(waddr) < CELLS))
    else $error("cell write out of range");

  // one item at a time: an accepted beat is followed by a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while busy");

  // a new result only comes from the result-load step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat without completion");

endmodule

`default_nettype wire

// ===== sim/atce_checker.sv =====
// Checker for the text console engine: watches both channels, predicts each
// result beat from a screen model of its own and compares. Depends on atce_pkg.
module atce_checker
  import atce_pkg::*;
#(
  parameter int unsigned COLUMNS = ColumnsDef,
  parameter int unsigned ROWS    = RowsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cells = COLUMNS * ROWS;

  typedef enum int {PsNormal, PsStart, PsFirst, PsSecond} parse_e;

  logic [7:0] scr_char [Cells];
  logic [7:0] scr_attr [Cells];
  int         cur_row, cur_col;
  logic [7:0] cur_attr;
  parse_e     pstate;
  int         num_a, num_b;
  out_t       expected_beats [$];
  int         fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_beats.size();

  function automatic logic [3:0] color_of(int k);
    logic [3:0] tab [8] = '{4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7};
    return tab[k];
  endfunction

  function automatic void fill(int lo, int hi, logic [7:0] at);
    if (hi > Cells) hi = Cells;
    for (int i = lo; i < hi; i++) begin
      scr_char[i] = 8'h00;
      scr_attr[i] = at;
    end
  endfunction

  // Move to next row, scrolling past the last one
  function automatic void new_line();
    cur_row++;
    cur_col = 0;
    if (cur_row >= ROWS) begin
      for (int i = 0; i + COLUMNS < Cells; i++) begin
        scr_char[i] = scr_char[i+COLUMNS];
        scr_attr[i] = scr_attr[i+COLUMNS];
      end
      fill((ROWS - 1) * COLUMNS, Cells, 8'h00);
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic void put_glyph(logic [7:0] b);
    int p;
    if (cur_col >= COLUMNS || b == NlByte) new_line();
    if (b != NlByte && b != 8'h00) begin
      p = cur_row * COLUMNS + cur_col;
      scr_char[p] = b;
      scr_attr[p] = cur_attr;
      cur_col++;
    end
  endfunction

  function automatic int saturate(int v, logic [7:0] b);
    v = v * 10 + (b - 8'h30);
    return v > 999 ? 999 : v;
  endfunction

  function automatic int clamp(int v, int hi);
    return v > hi ? hi : v;
  endfunction

  function automatic void sgr(int n);
    if (n == 0) cur_attr = AttrReset;
    else if (n >= 30 && n <= 37) cur_attr[3:0] = color_of(n - 30);
    else if (n >= 40 && n <= 47) cur_attr[7:4] = color_of(n - 40);
    else if (n >= 90 && n <= 97) cur_attr[3:0] = color_of(n - 90) + 4'd8;
    else if (n >= 100 && n <= 107) cur_attr[7:4] = color_of(n - 100) + 4'd8;
  endfunction

  function automatic void parse_char(logic [7:0] b);
    logic dig;
    int   cur, base, c;
    dig  = b >= "0" && b <= "9";
    cur  = cur_row * COLUMNS + cur_col;
    base = cur_row * COLUMNS;
    c    = clamp(cur_col, COLUMNS);
    if (pstate == PsNormal && b == EscByte) begin
      pstate = PsStart; num_a = 0; num_b = 0;
    end else if (pstate == PsStart && b == "[") pstate = PsFirst;
    else if (pstate == PsFirst && dig) num_a = saturate(num_a, b);
    else if (pstate == PsSecond && dig) num_b = saturate(num_b, b);
    else if (pstate == PsFirst && b == ";") pstate = PsSecond;
    else if (pstate == PsFirst && b == "G") begin
      cur_col = clamp(num_a, COLUMNS - 1); pstate = PsNormal;
    end else if (pstate == PsSecond && b == "H") begin
      cur_row = clamp(num_a, ROWS - 1);
      cur_col = clamp(num_b, COLUMNS - 1);
      pstate  = PsNormal;
    end else if (pstate == PsFirst && b == "J") begin
      if (num_a == 0) fill(cur, Cells, cur_attr);
      else if (num_a == 1) fill(0, cur, cur_attr);
      else fill(0, Cells, cur_attr);
      cur_row = 0; cur_col = 0; pstate = PsNormal;
    end else if (pstate == PsFirst && b == "K") begin
      if (num_a == 0) fill(base + c, base + COLUMNS, cur_attr);
      else if (num_a == 1) fill(base, base + c, cur_attr);
      else fill(base, base + COLUMNS, cur_attr);
      pstate = PsNormal;
    end else if (pstate == PsFirst && b == "m") begin
      sgr(num_a); pstate = PsNormal;
    end else if (pstate != PsNormal) pstate = PsNormal;
    else if (b == BsByte) begin
      if (cur_col == 0 && cur_row > 0) begin
        cur_row--; cur_col = COLUMNS - 1;
      end else if (cur_col > 0) cur_col--;
      cur = cur_row * COLUMNS + cur_col;
      scr_char[cur] = 8'h00;
      scr_attr[cur] = cur_attr;
    end else put_glyph(b);
  endfunction

  function automatic out_t predict_screen(in_t it);
    out_t r;
    r = '0;
    if (it.mode == ModeParse) parse_char(it.char_byte);
    else if (it.mode == ModeRaw) put_glyph(it.char_byte);
    else if (it.mode == ModeRead && it.read_cell < Cells) begin
      r.cell_char = scr_char[it.read_cell];
      r.cell_attr = scr_attr[it.read_cell];
    end
    r.cursor_cell = 11'(cur_row * COLUMNS + cur_col);
    r.cursor_row  = 5'(cur_row);
    r.cursor_col  = 7'(cur_col);
    r.attribute   = cur_attr;
    return r;
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      fill(0, Cells, AttrReset);
      cur_row = 0; cur_col = 0; cur_attr = AttrReset;
      pstate = PsNormal; num_a = 0; num_b = 0;
      expected_beats.delete();
      fails = 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_beats.push_back(predict_screen(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat %p", out_data_i);
        end else begin
          want = expected_beats.pop_front();
          if (want !== out_data_i) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p, got %p", want, out_data_i);
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb_ansi_text_console_engine_core.sv =====
// Testbench top for the text console engine: clock, reset and byte stimulus.
// Depends on atce_pkg, ansi_text_console_engine_core and atce_checker.
module tb_ansi_text_console_engine_core;
  import atce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   fail_count, pending;
  int   send_idle = 0, recv_idle = 0;

  always #5 clk_i = ~clk_i;

  ansi_text_console_engine_core dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  atce_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stall the result channel at random
  always @(posedge clk_i) out_stall <= ($urandom_range(99) < recv_idle);

  // Drive one beat and hold it until accepted; valid stays up for the next beat
  task automatic send_beat(logic [1:0] m, logic [7:0] b, logic [10:0] rc);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: m, char_byte: b, read_cell: rc};
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid after the last beat and let the checker see it
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(ModeParse, s[i], 11'($urandom));
  endtask

  task automatic send_read();
    send_beat(ModeRead, 8'($urandom), 11'($urandom_range(1999)));
  endtask

  // Random escape sequence, mostly well formed
  task automatic send_escape();
    string cmds = "GHJKm";
    int    k;
    k = $urandom_range(4);
    send_beat(ModeParse, EscByte, 11'($urandom));
    if ($urandom_range(9) == 0) begin
      send_beat(ModeParse, 8'($urandom), 11'($urandom));
      return;
    end
    send_text("[");
    if (k == 4) begin
      case ($urandom_range(4))
        0: send_text("0");
        1: send_text($sformatf("%0d", 30 + $urandom_range(7)));
        2: send_text($sformatf("%0d", 40 + $urandom_range(7)));
        3: send_text($sformatf("%0d", 90 + $urandom_range(17)));
        default: send_text($sformatf("%0d", $urandom_range(1200)));
      endcase
    end else if (k == 2 || k == 3) begin
      if ($urandom_range(3) != 0) send_text($sformatf("%0d", $urandom_range(2)));
      else if ($urandom_range(1)) send_text("77");
    end else send_text($sformatf("%0d", $urandom_range(k == 1 ? 30 : 90)));
    if (k == 1) begin
      send_text(";");
      send_text($sformatf("%0d", $urandom_range(90)));
    end
    if ($urandom_range(14) == 0) send_beat(ModeParse, 8'($urandom), 11'($urandom));
    else send_text(cmds.substr(k, k));
  endtask

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) send_beat(ModeParse, 8'($urandom_range(32, 126)), 11'($urandom));
      else if (r < 55) send_beat($urandom_range(1) ? ModeParse : ModeRaw, NlByte, 11'd0);
      else if (r < 60) send_beat(ModeParse, BsByte, 11'($urandom));
      else if (r < 72) send_read();
      else if (r < 80) send_escape();
      else if (r < 88) send_beat(ModeRaw, 8'($urandom), 11'($urandom));
      else send_beat(2'($urandom), 8'($urandom), 11'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty read, extremes, escapes, saturation, clamping
    send_beat(ModeRead, 8'hFF, 11'd0);
    send_beat(ModeRead, 8'h00, 11'd1999);
    send_beat(ModeRead, 8'h00, 11'h7FF);
    send_beat(2'd3, 8'hFF, 11'h7FF);
    send_beat(ModeParse, BsByte, 11'd0);
    send_beat(ModeRaw, 8'hFF, 11'h7FF);
    send_beat(ModeRaw, EscByte, 11'd0);
    send_beat(ModeRaw, BsByte, 11'd0);
    send_text("\033[1234;5678H");
    send_text("\033[97m\033[107m\033[55mA\033[2K");
    send_beat(ModeRead, 8'h00, 11'd1999);
    send_text("\033[24;0H\n\033xB\033[0J");
    send_read();
    // Sender idles 31%, receiver 52%
    send_idle = 31; recv_idle = 52;
    random_phase(400);
    // Hold off until every result beat is back
    idle_input();
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    send_idle = 52; recv_idle = 31;
    random_phase(400);
    send_idle = 0; recv_idle = 0;
    random_phase(400);
    idle_input();
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
design/atce_pkg.sv
design/ansi_text_console_engine_core.sv
sim/atce_checker.sv
sim/tb_ansi_text_console_engine_core.sv
